// ===== design/hsfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types, constants and the CRC-8 byte update for the sensor frame
// checker and converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // byte positions within a six-byte reply
  localparam logic [2:0] POS_A_HI   = 3'd0;
  localparam logic [2:0] POS_A_LO   = 3'd1;
  localparam logic [2:0] POS_A_CRC  = 3'd2;
  localparam logic [2:0] POS_B_HI   = 3'd3;
  localparam logic [2:0] POS_B_LO   = 3'd4;
  localparam logic [2:0] POS_B_CRC  = 3'd5;
  localparam logic [2:0] POS_LAST   = POS_B_CRC;

  // frame_mode codes
  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_SERIAL  = 1'b1;

  // conversion constants
  localparam int FULL_SCALE  = 65535;
  localparam int HALF_SCALE  = FULL_SCALE / 2;
  localparam int TEMP_SPAN   = 17500;
  localparam int TEMP_OFFSET = 4500;
  localparam int HUM_SPAN    = 12500;
  localparam int HUM_OFFSET  = 600;
  localparam int HUM_MAX     = 10000;

  // one checked reply, handed from the front end to the converter
  typedef struct packed {
    logic        crc_bad;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        mode;
  } frame_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/hsfc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_front
// Byte assembler: tracks the position in the reply, runs the CRC and hands
// one frame record to the queue on the sixth byte.
// ----------------------------------------------------------------------------
module hsfc_front import hsfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  logic       frame_mode,
  output logic       rec_push,
  output frame_t     rec_data
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        first_bad_r, first_bad_nxt;
  logic [15:0] first_word_r, first_word_nxt;
  logic [7:0]  second_hi_r, second_hi_nxt;
  logic [7:0]  second_lo_r, second_lo_nxt;
  logic [2:0]  pos_eff;

  // a frame start or a stray position restarts at the first byte
  assign pos_eff = (frame_start || pos_r > POS_LAST) ? POS_A_HI : pos_r;

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    first_bad_nxt  = first_bad_r;
    first_word_nxt = first_word_r;
    second_hi_nxt  = second_hi_r;
    second_lo_nxt  = second_lo_r;
    rec_push       = 1'b0;
    rec_data.crc_bad     = first_bad_r | (crc_r != rx_byte);
    rec_data.first_word  = first_word_r;
    rec_data.second_word = {second_hi_r, second_lo_r};
    rec_data.mode        = frame_mode;
    if (byte_valid) begin
      case (pos_eff)
        POS_A_HI: begin
          crc_nxt        = crc_byte(CRC_INIT, rx_byte);
          first_word_nxt = {rx_byte, 8'h00};
          pos_nxt        = POS_A_LO;
        end
        POS_A_LO: begin
          crc_nxt        = crc_byte(crc_r, rx_byte);
          first_word_nxt = {first_word_r[15:8], rx_byte};
          pos_nxt        = POS_A_CRC;
        end
        POS_A_CRC: begin
          first_bad_nxt = (crc_r != rx_byte);
          crc_nxt       = CRC_INIT;
          pos_nxt       = POS_B_HI;
        end
        POS_B_HI: begin
          crc_nxt       = crc_byte(CRC_INIT, rx_byte);
          second_hi_nxt = rx_byte;
          pos_nxt       = POS_B_LO;
        end
        POS_B_LO: begin
          crc_nxt       = crc_byte(crc_r, rx_byte);
          second_lo_nxt = rx_byte;
          pos_nxt       = POS_B_CRC;
        end
        default: begin
          rec_push = 1'b1;
          crc_nxt  = CRC_INIT;
          pos_nxt  = POS_A_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_A_HI;
      crc_r       <= CRC_INIT;
      first_bad_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      first_bad_r <= first_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_word_r <= first_word_nxt;
    second_hi_r  <= second_hi_nxt;
    second_lo_r  <= second_lo_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position out of range");

endmodule

// ===== design/hsfc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_queue
// Two-entry queue of frame records between the front end and the converter.
// ----------------------------------------------------------------------------
module hsfc_queue import hsfc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t wdata,
  output logic   full,
  input  logic   pop,
  output frame_t rdata,
  output logic   empty
);

  frame_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

// ===== design/hsfc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_back
// Converter: scales raw ticks to centidegrees and centipercent (zero in serial mode) in a
// three-stage pipeline; the last stage is the result register.
// ----------------------------------------------------------------------------
module hsfc_back import hsfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_empty,
  input  frame_t             rec_data,
  output logic               rec_pop,
  output logic               res_valid,
  input  logic               res_pop,
  output logic               res_crc_status,
  output logic [15:0]        res_first_word,
  output logic [15:0]        res_second_word,
  output logic signed [14:0] res_temperature_centi,
  output logic [13:0]        res_humidity_centi,
  output logic [31:0]        res_unit_id
);

  // x / 65535: the estimate is low by at most one, fixed with one compare
  function automatic logic [15:0] div_est(input logic [31:0] x);
    logic [31:0] s;
    s = x + (x >> 16);
    return s[31:16];
  endfunction

  function automatic logic [15:0] div_fix(input logic [31:0] x, input logic [15:0] est);
    logic [31:0] r;
    r = x - ({est, 16'h0000} - 32'(est));
    return est + 16'(r >= 32'(FULL_SCALE));
  endfunction

  logic        adv;
  logic        v1_r, v2_r, v3_r;
  frame_t      f1_r, f2_r;
  logic [30:0] t_prod_r;
  logic [29:0] h_prod_r;
  logic [31:0] t_x_r, h_x_r;
  logic [15:0] t_est_r, h_est_r;
  logic [31:0] t_x_nxt, h_x_nxt;
  logic [15:0] t_q, h_q;
  logic signed [16:0] t_off;
  logic [13:0] hum_nxt;

  // whole pipeline moves together whenever the result register can take data
  assign adv     = !v3_r || res_pop;
  assign rec_pop = adv && !rec_empty;
  assign res_valid = v3_r;

  assign t_x_nxt = 32'(t_prod_r) + 32'(HALF_SCALE);
  assign h_x_nxt = 32'(h_prod_r) + 32'(HALF_SCALE);

  assign t_q   = div_fix(t_x_r, t_est_r);
  assign h_q   = div_fix(h_x_r, h_est_r);
  assign t_off = $signed({1'b0, t_q}) - 17'sd4500;

  always_comb begin
    if (h_q < 16'(HUM_OFFSET))                 hum_nxt = 14'd0;
    else if (h_q > 16'(HUM_OFFSET + HUM_MAX))  hum_nxt = 14'(HUM_MAX);
    else                                       hum_nxt = 14'(h_q - 16'(HUM_OFFSET));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= !rec_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r     <= rec_data;
      t_prod_r <= 31'(rec_data.first_word) * 31'(TEMP_SPAN);
      h_prod_r <= 30'(rec_data.second_word) * 30'(HUM_SPAN);
      f2_r     <= f1_r;
      t_x_r    <= t_x_nxt;
      h_x_r    <= h_x_nxt;
      t_est_r  <= div_est(t_x_nxt);
      h_est_r  <= div_est(h_x_nxt);
      res_crc_status    <= f2_r.crc_bad;
      res_first_word    <= f2_r.first_word;
      res_second_word   <= f2_r.second_word;
      res_unit_id       <= {f2_r.first_word, f2_r.second_word};
      if (f2_r.mode == MODE_SERIAL) begin
        res_temperature_centi <= 15'sd0;
        res_humidity_centi    <= 14'd0;
      end else begin
        res_temperature_centi <= t_off[14:0];
        res_humidity_centi    <= hum_nxt;
      end
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !res_pop |=> v3_r && $stable(res_unit_id)
                         && $stable(res_temperature_centi))
    else $error("waiting result changed before pop");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> res_humidity_centi <= 14'(HUM_MAX))
    else $error("humidity out of range");

endmodule

// ===== design/humidity_sensor_frame_check_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_check_convert
// Sensor reply checker: CRC-8 check of a six-byte reply and conversion of
// the two raw words to temperature and humidity.
// ----------------------------------------------------------------------------
// Takes one reply byte per clock, every cycle, for as long as in_full is low.
// A byte assembler runs the CRC-8 (poly 0x31, init 0xFF) one byte per cycle;
// on the sixth byte it places a frame record in a two-entry queue, and a
// three-stage scaling pipeline, whose last stage is the result register,
// takes it to the out_ ports while the result register is free. in_full is
// high while the queue holds two unconverted frames, which happens only
// after results have been left waiting. frame_mode is sampled when the
// sixth byte of a reply is accepted; in_frame_start restarts the count.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_check_convert import hsfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_crc_status,
  output logic [15:0]        out_first_word,
  output logic [15:0]        out_second_word,
  output logic signed [14:0] out_temperature_centi,
  output logic [13:0]        out_humidity_centi,
  output logic [31:0]        out_unit_id,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_frame_mode
);

  logic   frame_mode_r;
  logic   byte_take;
  logic   q_push, q_full, q_pop, q_empty;
  frame_t q_wdata, q_rdata;
  logic   res_valid;

  assign cfg_ready = 1'b1;
  assign byte_take = in_push && !in_full;
  assign in_full   = q_full;
  assign out_empty = !res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r <= MODE_MEASURE;
    end else if (cfg_valid && cfg_ready) begin
      frame_mode_r <= cfg_frame_mode;
    end
  end

  hsfc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_take),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .frame_mode  (frame_mode_r),
    .rec_push    (q_push),
    .rec_data    (q_wdata)
  );

  hsfc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  hsfc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .rec_empty             (q_empty),
    .rec_data              (q_rdata),
    .rec_pop               (q_pop),
    .res_valid             (res_valid),
    .res_pop               (out_pop),
    .res_crc_status        (out_crc_status),
    .res_first_word        (out_first_word),
    .res_second_word       (out_second_word),
    .res_temperature_centi (out_temperature_centi),
    .res_humidity_centi    (out_humidity_centi),
    .res_unit_id           (out_unit_id)
  );

endmodule

// ===== test/humidity_sensor_frame_check_convert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_check_convert_tb
// Self-checking bench for the sensor reply checker. Six-byte replies (word,
// CRC, word, CRC) are fed through the push/full side with random gaps and
// popped with random stalls. A cycle-free predictor tracks byte position,
// CRC-8 and the fixed-point conversions and checks every popped result.
// Runs measurement and serial modes, good and corrupted CRCs, truncated
// replies, restarts and stray bytes.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_check_convert_tb;
  import hsfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } reply_byte_t;

  typedef struct {
    logic               crc_bad;
    logic [15:0]        word_a;
    logic [15:0]        word_b;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic [31:0]        serial;
  } reading_t;

  typedef enum int {FAULT_NONE, FAULT_FIRST, FAULT_SECOND, FAULT_BOTH} frame_fault_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               in_frame_start = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_crc_status;
  logic [15:0]        out_first_word;
  logic [15:0]        out_second_word;
  logic signed [14:0] out_temperature_centi;
  logic [13:0]        out_humidity_centi;
  logic [31:0]        out_unit_id;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_frame_mode = MODE_MEASURE;

  humidity_sensor_frame_check_convert i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_rx_byte            (in_rx_byte),
    .in_frame_start        (in_frame_start),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_crc_status        (out_crc_status),
    .out_first_word        (out_first_word),
    .out_second_word       (out_second_word),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_unit_id           (out_unit_id),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_frame_mode        (cfg_frame_mode)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  reply_byte_t byte_backlog[$];
  reading_t    due_readings[$];
  int          queued_count = 0;
  int          taken_count = 0;
  int          mismatch_count = 0;

  // predictor state
  logic        mode_q = MODE_MEASURE;
  logic [2:0]  frame_pos = POS_A_HI;
  logic [7:0]  crc_acc = CRC_INIT;
  logic [15:0] word_a_q = '0;
  logic [15:0] word_b_q = '0;
  logic        a_bad_q = 1'b0;

  // bit-serial form of the CRC-8 update, MSB first
  function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic reading_t convert_frame(input logic bad, input logic [15:0] a,
                                             input logic [15:0] w, input logic mode);
    reading_t rd;
    int       t;
    int       h;
    rd.crc_bad = bad;
    rd.word_a  = a;
    rd.word_b  = w;
    rd.serial  = {a, w};
    if (mode == MODE_MEASURE) begin
      // odd divisor, so adding half the scale never lands on a tie
      t = (TEMP_SPAN * int'(a) + HALF_SCALE) / FULL_SCALE - TEMP_OFFSET;
      h = (HUM_SPAN * int'(w) + HALF_SCALE) / FULL_SCALE - HUM_OFFSET;
      if (h < 0) h = 0;
      if (h > HUM_MAX) h = HUM_MAX;
    end else begin
      t = 0;
      h = 0;
    end
    rd.temp_centi = t[14:0];
    rd.hum_centi  = h[13:0];
    return rd;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic start);
    if (start || frame_pos > POS_LAST) frame_pos = POS_A_HI;
    case (frame_pos)
      POS_A_HI: begin
        crc_acc = crc8_shift(CRC_INIT, b);
        word_a_q[15:8] = b;
        frame_pos = POS_A_LO;
      end
      POS_A_LO: begin
        crc_acc = crc8_shift(crc_acc, b);
        word_a_q[7:0] = b;
        frame_pos = POS_A_CRC;
      end
      POS_A_CRC: begin
        a_bad_q = (crc_acc != b);
        crc_acc = CRC_INIT;
        frame_pos = POS_B_HI;
      end
      POS_B_HI: begin
        crc_acc = crc8_shift(CRC_INIT, b);
        word_b_q[15:8] = b;
        frame_pos = POS_B_LO;
      end
      POS_B_LO: begin
        crc_acc = crc8_shift(crc_acc, b);
        word_b_q[7:0] = b;
        frame_pos = POS_B_CRC;
      end
      default: begin
        due_readings.push_back(convert_frame(a_bad_q | (crc_acc != b), word_a_q, word_b_q,
                                             mode_q));
        crc_acc = CRC_INIT;
        frame_pos = POS_A_HI;
      end
    endcase
  endtask

  task automatic check_reading();
    reading_t rd;
    if (due_readings.size() == 0) begin
      $error("result popped with nothing outstanding: first_word %0h", out_first_word);
      mismatch_count++;
    end else begin
      rd = due_readings.pop_front();
      if (out_crc_status !== rd.crc_bad) begin
        $error("crc_status: expected %0d, got %0d", rd.crc_bad, out_crc_status);
        mismatch_count++;
      end
      if (out_first_word !== rd.word_a) begin
        $error("first_word: expected %0h, got %0h", rd.word_a, out_first_word);
        mismatch_count++;
      end
      if (out_second_word !== rd.word_b) begin
        $error("second_word: expected %0h, got %0h", rd.word_b, out_second_word);
        mismatch_count++;
      end
      if (out_temperature_centi !== rd.temp_centi) begin
        $error("temperature_centi: expected %0d, got %0d", rd.temp_centi,
               out_temperature_centi);
        mismatch_count++;
      end
      if (out_humidity_centi !== rd.hum_centi) begin
        $error("humidity_centi: expected %0d, got %0d", rd.hum_centi, out_humidity_centi);
        mismatch_count++;
      end
      if (out_unit_id !== rd.serial) begin
        $error("unit_id: expected %0h, got %0h", rd.serial, out_unit_id);
        mismatch_count++;
      end
    end
  endtask

  // mostly no gap, some short, a few long, and now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // request driver
  int in_gap = 0;
  int in_calm = 0;

  always @(posedge clk) begin
    reply_byte_t it;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || !in_full) begin
      if (in_gap > 0) begin
        in_gap--;
        in_push <= 1'b0;
      end else if (byte_backlog.size() > 0) begin
        it = byte_backlog.pop_front();
        in_rx_byte     <= it.data;
        in_frame_start <= it.start;
        in_push        <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // result side back-pressure
  int out_stall = 0;
  int out_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      out_stall = pick_gap(out_calm);
    end
  end

  // monitor: config, accepted requests, popped results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) mode_q = cfg_frame_mode;
      if (out_pop && !out_empty) check_reading();
      if (in_push && !in_full) begin
        absorb_byte(in_rx_byte, in_frame_start);
        taken_count++;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("humidity_sensor_frame_check_convert_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic queue_byte(input logic [7:0] b, input logic s);
    reply_byte_t it;
    it.data  = b;
    it.start = s;
    byte_backlog.push_back(it);
    queued_count++;
  endtask

  task automatic queue_frame(input logic [15:0] a, input logic [15:0] w, input logic s,
                             input frame_fault_t fault);
    logic [7:0] crc_a;
    logic [7:0] crc_b;
    crc_a = crc8_shift(crc8_shift(CRC_INIT, a[15:8]), a[7:0]);
    crc_b = crc8_shift(crc8_shift(CRC_INIT, w[15:8]), w[7:0]);
    if (fault == FAULT_FIRST || fault == FAULT_BOTH)
      crc_a ^= 8'(1 << $urandom_range(0, 7));
    if (fault == FAULT_SECOND || fault == FAULT_BOTH)
      crc_b ^= 8'(1 << $urandom_range(0, 7));
    queue_byte(a[15:8], s);
    queue_byte(a[7:0], 1'b0);
    queue_byte(crc_a, 1'b0);
    queue_byte(w[15:8], 1'b0);
    queue_byte(w[7:0], 1'b0);
    queue_byte(crc_b, 1'b0);
  endtask

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // mostly whole replies, some with CRC faults, the rest truncated replies and stray bytes
  task automatic queue_random(input int budget);
    int           stop_at;
    int           r;
    int           n;
    bit           aligned;
    frame_fault_t fault;
    stop_at = queued_count + budget;
    aligned = 1'b0;
    while (queued_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        n = $urandom_range(0, 99);
        fault = (n < 85) ? FAULT_NONE : frame_fault_t'($urandom_range(1, 3));
        queue_frame(pick_word(), pick_word(), aligned ? 1'($urandom) : 1'b1, fault);
        aligned = 1'b1;
      end else if (r < 90) begin
        n = $urandom_range(1, 5);
        queue_byte(8'($urandom), 1'b1);
        for (int i = 1; i < n; i++) queue_byte(8'($urandom), 1'b0);
        aligned = 1'b0;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
        aligned = 1'b0;
      end
    end
  endtask

  // wait for every request taken and every result popped, then let the
  // pipeline run dry in case the last bytes were a partial reply
  task automatic settle();
    while (taken_count != queued_count || due_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_frame_mode <= m;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // measurement mode: scale ends, clamps, restart, CRC faults
    queue_frame(16'h0000, 16'h0000, 1'b1, FAULT_NONE);
    queue_frame(16'hFFFF, 16'hFFFF, 1'b0, FAULT_NONE);
    queue_byte(8'hA5, 1'b1);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'h3C, 1'b0);
    queue_frame(16'h6666, 16'h8000, 1'b1, FAULT_FIRST);
    queue_frame(16'h1234, 16'hABCD, 1'b1, FAULT_SECOND);
    queue_random(250);

    write_mode(MODE_SERIAL);
    queue_frame(16'hFFFF, 16'h0000, 1'b1, FAULT_NONE);
    queue_frame(16'h0000, 16'hFFFF, 1'b1, FAULT_BOTH);
    queue_random(220);

    write_mode(MODE_MEASURE);
    queue_random(220);

    write_mode(MODE_SERIAL);
    queue_random(220);

    write_mode(MODE_MEASURE);
    queue_frame(16'h8000, 16'h7FFF, 1'b1, FAULT_NONE);

    settle();
    if (mismatch_count == 0)
      $display("humidity_sensor_frame_check_convert_tb OK");
    else
      $display("humidity_sensor_frame_check_convert_tb NOT OK");
    $finish;
  end

endmodule
